// ===== sv/wpjc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpjc_pkg
// Shared types, register indexes and helpers of the windowed pid controller.
// ----------------------------------------------------------------------------
package wpjc_pkg;

  localparam int INTEGRAL_WINDOW_DEF   = 64;
  localparam int DERIVATIVE_WINDOW_DEF = 8;

  localparam int CFG_IDX_W = 8;
  localparam int REG_W     = 16;
  localparam int ERR_W     = 17;
  localparam int GAIN_W    = REG_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_KP_NUM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KP_DEN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KI_NUM = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KI_DEN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_KD_NUM = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_KD_DEN = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = CFG_IDX_W'(7);

  localparam logic [REG_W-1:0] RATE_RESET = REG_W'(1000);

  typedef struct packed {
    logic signed [15:0] measured_position;
    logic signed [15:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [REG_W-1:0]     value;
  } cfg_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_DERIV_RAW,
    OP_INTEG_RAW,
    OP_PROP,
    OP_INTEG,
    OP_DERIV
  } op_e;

  typedef struct packed {
    logic load_in;
    logic hist;
    logic mul;
    logic div_start;
    logic div_take;
    logic out_load;
    op_e  op;
  } dp_cmd_t;

  // zero used as a divisor counts as one
  function automatic logic [REG_W-1:0] div_of(input logic [REG_W-1:0] r);
    div_of = (r == '0) ? REG_W'(1) : r;
  endfunction

endpackage

// ===== sv/wpjc_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpjc_stream_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface wpjc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/wpjc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpjc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpjc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/wpjc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpjc_div
// Signed by unsigned 16-bit divider, truncating, four quotient bits a cycle.
// ----------------------------------------------------------------------------
module wpjc_div #(
  parameter int DVD_W = 52
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [15:0]             divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);

  localparam int DIV_W = ((DVD_W + 3) / 4) * 4;
  localparam int STEPS = DIV_W / 4;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [15:0]      rem_q, rem_d;
  logic [15:0]      den_q, den_d;
  logic             neg_q, neg_d;
  logic [DVD_W-1:0] mag;

  assign mag = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);

  always_comb begin
    logic [16:0]      r;
    logic [DIV_W-1:0] q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    r      = {1'b0, rem_q};
    q      = quo_q;
    for (int k = 0; k < 4; k++) begin
      r = {r[15:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r    = r - {1'b0, den_q};
        q[0] = 1'b1;
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(STEPS);
      quo_d  = DIV_W'(mag);
      rem_d  = '0;
      den_d  = divisor_i;
      neg_d  = dividend_i[DVD_W-1];
    end else if (busy_q) begin
      quo_d = q;
      rem_d = r[15:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q[DVD_W-1:0]) : $signed(quo_q[DVD_W-1:0]);

endmodule

// ===== sv/wpjc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpjc_dp
// Datapath: gain registers, error histories, running sum, multiplier,
// shared divider, accumulator and the saturated drive register.
// ----------------------------------------------------------------------------
module wpjc_dp #(
  parameter int IW = 64,
  parameter int DW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wpjc_pkg::dp_cmd_t    cmd_i,
  input  wpjc_pkg::in_item_t   in_data_i,
  input  logic                 cfg_valid_i,
  input  wpjc_pkg::cfg_item_t  cfg_data_i,
  output logic                 div_done_o,
  output wpjc_pkg::out_item_t  out_data_o
);
  import wpjc_pkg::*;

  localparam int IAW    = (IW > 1) ? $clog2(IW) : 1;
  localparam int DAW    = (DW > 1) ? $clog2(DW) : 1;
  localparam int SUM_W  = ERR_W + $clog2(IW);
  localparam int DIFF_W = ERR_W + 1;
  localparam int DRAW_W = DIFF_W + GAIN_W;
  localparam int MA_W   = (SUM_W > DRAW_W) ? SUM_W : DRAW_W;
  localparam int PROD_W = MA_W + GAIN_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7fffffff);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sh80000000);

  logic [REG_W-1:0] kp_num_q, kp_den_q, ki_num_q, ki_den_q;
  logic [REG_W-1:0] kd_num_q, kd_den_q, off_q, rate_q;

  logic signed [ERR_W-1:0]  err_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [SUM_W-1:0]  integ_q;
  logic signed [DRAW_W-1:0] deriv_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [31:0]       drive_q;

  logic [IAW-1:0] islot_q;
  logic [DAW-1:0] dslot_q;
  logic           ifull_q, dfull_q;

  logic [ERR_W-1:0]         irdata, drdata;
  logic signed [ERR_W-1:0]  old_i, old_d;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_res;
  logic signed [PROD_W-1:0] dvd;
  logic [REG_W-1:0]         dvs;
  logic signed [PROD_W-1:0] div_q;
  logic [REG_W-1:0]         rate_eff;

  assign rate_eff = div_of(rate_q);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_num_q <= REG_W'(1);
      kp_den_q <= REG_W'(1);
      ki_num_q <= '0;
      ki_den_q <= REG_W'(1);
      kd_num_q <= '0;
      kd_den_q <= REG_W'(1);
      off_q    <= '0;
      rate_q   <= RATE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_data_i.reg_index)
        REG_KP_NUM: kp_num_q <= cfg_data_i.value;
        REG_KP_DEN: kp_den_q <= cfg_data_i.value;
        REG_KI_NUM: ki_num_q <= cfg_data_i.value;
        REG_KI_DEN: ki_den_q <= cfg_data_i.value;
        REG_KD_NUM: kd_num_q <= cfg_data_i.value;
        REG_KD_DEN: kd_den_q <= cfg_data_i.value;
        REG_OFFSET: off_q    <= cfg_data_i.value;
        REG_RATE:   rate_q   <= cfg_data_i.value;
        default: ;
      endcase
    end
  end

  // error histories
  wpjc_ram #(.WIDTH(ERR_W), .DEPTH(IW), .AW(IAW)) u_integ_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist),
    .waddr_i (islot_q),
    .wdata_i (err_q),
    .raddr_i (islot_q),
    .rdata_o (irdata)
  );

  wpjc_ram #(.WIDTH(ERR_W), .DEPTH(DW), .AW(DAW)) u_deriv_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist),
    .waddr_i (dslot_q),
    .wdata_i (err_q),
    .raddr_i (dslot_q),
    .rdata_o (drdata)
  );

  // entries not yet written count as zero
  assign old_i = ifull_q ? $signed(irdata) : '0;
  assign old_d = dfull_q ? $signed(drdata) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      islot_q <= '0;
      dslot_q <= '0;
      ifull_q <= 1'b0;
      dfull_q <= 1'b0;
    end else if (cmd_i.hist) begin
      sum_q <= sum_q - SUM_W'(old_i) + SUM_W'(err_q);
      if (islot_q == IAW'(IW - 1)) begin
        islot_q <= '0;
        ifull_q <= 1'b1;
      end else begin
        islot_q <= islot_q + IAW'(1);
      end
      if (dslot_q == DAW'(DW - 1)) begin
        dslot_q <= '0;
        dfull_q <= 1'b1;
      end else begin
        dslot_q <= dslot_q + DAW'(1);
      end
    end
  end

  // operand selection
  always_comb begin
    case (cmd_i.op)
      OP_DERIV_RAW: begin
        mul_a = MA_W'(diff_q);
        mul_b = $signed({1'b0, rate_eff});
        dvd   = prod_q;
        dvs   = REG_W'(DW);
      end
      OP_INTEG_RAW: begin
        mul_a = MA_W'(integ_q);
        mul_b = $signed({1'b0, ki_num_q});
        dvd   = PROD_W'(sum_q);
        dvs   = rate_eff;
      end
      OP_PROP: begin
        mul_a = MA_W'(err_q);
        mul_b = $signed({1'b0, kp_num_q});
        dvd   = prod_q;
        dvs   = div_of(kp_den_q);
      end
      OP_INTEG: begin
        mul_a = MA_W'(integ_q);
        mul_b = $signed({1'b0, ki_num_q});
        dvd   = prod_q;
        dvs   = div_of(ki_den_q);
      end
      OP_DERIV: begin
        mul_a = MA_W'(deriv_q);
        mul_b = $signed({1'b0, kd_num_q});
        dvd   = prod_q;
        dvs   = div_of(kd_den_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        dvd   = prod_q;
        dvs   = REG_W'(1);
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  wpjc_div #(.DVD_W(PROD_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done_o),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      err_q <= ERR_W'(in_data_i.measured_position) - ERR_W'(in_data_i.target_position);
    end
    if (cmd_i.hist) begin
      diff_q <= DIFF_W'(err_q) - DIFF_W'(old_d);
    end
    if (cmd_i.mul) begin
      prod_q <= mul_res;
    end
    if (cmd_i.div_take) begin
      case (cmd_i.op)
        OP_DERIV_RAW: deriv_q <= div_q[DRAW_W-1:0];
        OP_INTEG_RAW: integ_q <= div_q[SUM_W-1:0];
        OP_PROP:      acc_q   <= ACC_W'(div_q) + $signed(ACC_W'(off_q));
        default:      acc_q   <= acc_q + ACC_W'(div_q);
      endcase
    end
    if (cmd_i.out_load) begin
      if (acc_q > SAT_MAX) begin
        drive_q <= 32'sh7fffffff;
      end else if (acc_q < SAT_MIN) begin
        drive_q <= 32'sh80000000;
      end else begin
        drive_q <= acc_q[31:0];
      end
    end
  end

  assign out_data_o.drive = drive_q;

endmodule

// ===== sv/wpjc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpjc_ctrl
// Sequencer: steps one item through history update, multiplies and
// divisions, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module wpjc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              div_done_i,
  output wpjc_pkg::dp_cmd_t cmd_o
);
  import wpjc_pkg::*;

  ctrl_state_e state_q, state_d;
  op_e         op_q, op_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DERIV_RAW;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '{load_in: 1'b0, hist: 1'b0, mul: 1'b0, div_start: 1'b0,
                    div_take: 1'b0, out_load: 1'b0, op: op_q};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.hist = 1'b1;
        op_d       = OP_DERIV_RAW;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done_i) begin
          cmd_o.div_take = 1'b1;
          case (op_q)
            OP_DERIV_RAW: begin
              op_d    = OP_INTEG_RAW;
              state_d = ST_DIV_GO;
            end
            OP_INTEG_RAW: begin
              op_d    = OP_PROP;
              state_d = ST_MUL;
            end
            OP_PROP: begin
              op_d    = OP_INTEG;
              state_d = ST_MUL;
            end
            OP_INTEG: begin
              op_d    = OP_DERIV;
              state_d = ST_MUL;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/windowed_pid_joint_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_pid_joint_controller
// One joint channel of a pid controller with a moving-window integral and
// a windowed-difference derivative, drive saturated to signed 32 bits.
// ----------------------------------------------------------------------------
//  channel  dir  payload                               handshake
//  in_i     in   measured_position, target_position    valid / ready
//  out_o    out  drive                                 valid / ready
//  cfg_i    in   reg_index, value                      valid / ready (always ready)
//
//  One item at a time, paced by the shared divider that retires four quotient
//  bits a cycle for five divisions in a row.
//  Reset clears the gains to their defaults and empties both histories through
//  fill flags, so no clearing pass is needed. A held result stalls only the
//  end of the following item; the next item is taken while it waits.
// ----------------------------------------------------------------------------
module windowed_pid_joint_controller #(
  parameter int INTEGRAL_WINDOW   = wpjc_pkg::INTEGRAL_WINDOW_DEF,
  parameter int DERIVATIVE_WINDOW = wpjc_pkg::DERIVATIVE_WINDOW_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wpjc_stream_if.sink   in_i,
  wpjc_stream_if.source out_o,
  wpjc_stream_if.sink   cfg_i
);
  import wpjc_pkg::*;

  dp_cmd_t   cmd;
  logic      div_done;
  out_item_t out_data;

  assign cfg_i.ready = 1'b1;
  assign out_o.data  = out_data;

  wpjc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  wpjc_dp #(.IW(INTEGRAL_WINDOW), .DW(DERIVATIVE_WINDOW)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .div_done_o  (div_done),
    .out_data_o  (out_data)
  );

endmodule
